### hdl/rpct_pkg.sv
package rpct_pkg;

    localparam int PAGE_ROWS  = 8;
    localparam int STORE_ROWS = PAGE_ROWS - 1;

    typedef logic [STORE_ROWS-1:0][7:0] t_store_word;

    // gather bit c of each row byte into column byte c
    function automatic logic [63:0] transpose8(input t_store_word rows, input logic [7:0] last);
        logic [PAGE_ROWS-1:0][7:0] all_rows;
        logic [63:0]               result;
        all_rows = {last, rows};
        result   = '0;
        for (int c = 0; c < 8; c++) begin
            for (int k = 0; k < PAGE_ROWS; k++) begin
                result[8*c+k] = all_rows[k][c];
            end
        end
        return result;
    endfunction

endpackage

### hdl/raster_to_page_column_transposer.sv
// Raster to page column transposer.
// Input channel: i_valid / o_stall / i_pixel_byte carries a monochrome frame one byte
// per request, row-major, bit b of a byte is column 8*byte+b of its row.
// Output channel: o_valid / i_stall carries one request per byte of the last row of each
// full 8-row page: o_column_bytes holds eight column bytes (byte c is column
// 8*o_column_group+c, bit k is page row k), o_page_index the page and o_frame_end marks
// the last request of the frame. Rows 0 to 6 of a page go into a store of WIDTH/8 words
// (one byte lane per row) and produce nothing; rows of a partial last page are dropped.
// Throughput: one input request per cycle while o_stall is low.
// A result passes the store read register, then the output register, on its way out.
// Reset clears the position counters and all valid flags; the store needs no clearing.
// While i_stall is high the output request holds; the stage ahead of it still takes one
// more result and input bytes that produce no result keep flowing until that stage fills,
// then o_stall rises.
module raster_to_page_column_transposer #(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_pixel_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_column_bytes,
    output logic [2:0]  o_page_index,
    output logic [3:0]  o_column_group,
    output logic        o_frame_end
);
    import rpct_pkg::*;

    localparam int BPR       = WIDTH / 8;
    localparam int CW        = (BPR > 1) ? $clog2(BPR) : 1;
    localparam int RW        = $clog2(HEIGHT);
    localparam int ROWS_FULL = (HEIGHT / PAGE_ROWS) * PAGE_ROWS;

    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    t_store_word     r_mem [BPR];
    t_store_word     r_rd;
    logic            r_s1_vld;
    logic [7:0]      r_s1_px;
    logic [2:0]      r_s1_page;
    logic [3:0]      r_s1_grp;
    logic            r_s1_end;
    logic            r_o_vld;
    logic [63:0]     r_o_bytes;
    logic [2:0]      r_o_page;
    logic [3:0]      r_o_grp;
    logic            r_o_end;

    logic            out_ready;
    logic            s1_adv;
    logic            s1_free;
    logic            accept;
    logic            in_full;
    logic [2:0]      row_in_page;
    logic            last_row;
    logic [RW+2:0]   row_x;
    logic [CW+3:0]   col_x;
    logic            n_s1_vld;
    logic            n_o_vld;

    assign out_ready   = !r_o_vld || !i_stall;
    assign s1_adv      = r_s1_vld && out_ready;
    assign s1_free     = !r_s1_vld || out_ready;
    assign o_stall     = !s1_free;
    assign accept      = i_valid && s1_free;
    assign in_full     = {1'b0, r_row} < (RW+1)'(ROWS_FULL);
    assign row_in_page = r_row[2:0];
    assign last_row    = row_in_page == 3'(PAGE_ROWS - 1);
    assign row_x       = {3'b000, r_row};
    assign col_x       = {4'b0000, r_col};

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (s1_adv) begin
            n_s1_vld = 1'b0;
        end
        if (accept && in_full && last_row) begin
            n_s1_vld = 1'b1;
        end
        n_o_vld = r_o_vld;
        if (out_ready) begin
            n_o_vld = s1_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_o_vld  <= n_o_vld;
            if (accept) begin
                if (r_col == CW'(BPR - 1)) begin
                    r_col <= '0;
                    if (r_row == RW'(HEIGHT - 1)) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && in_full && !last_row) begin
            r_mem[r_col][row_in_page] <= i_pixel_byte;
        end
        if (accept && in_full && last_row) begin
            r_rd      <= r_mem[r_col];
            r_s1_px   <= i_pixel_byte;
            r_s1_page <= row_x[5:3];
            r_s1_grp  <= col_x[3:0];
            r_s1_end  <= (r_row == RW'(ROWS_FULL - 1)) && (r_col == CW'(BPR - 1));
        end
        if (s1_adv) begin
            r_o_bytes <= transpose8(r_rd, r_s1_px);
            r_o_page  <= r_s1_page;
            r_o_grp   <= r_s1_grp;
            r_o_end   <= r_s1_end;
        end
    end

    assign o_valid        = r_o_vld;
    assign o_column_bytes = r_o_bytes;
    assign o_page_index   = r_o_page;
    assign o_column_group = r_o_grp;
    assign o_frame_end    = r_o_end;

endmodule

### bench/tb_top.sv
module tb_top;

    localparam int WIDTH         = 128;
    localparam int HEIGHT        = 64;
    localparam int BYTES_PER_ROW = WIDTH / 8;
    localparam int FULL_PAGES    = HEIGHT / rpct_pkg::PAGE_ROWS;
    localparam int RANDOM_PIXELS = 1100;
    localparam int QUIET_FIRST   = 300;
    localparam int QUIET_LAST    = 700;
    localparam int DRAIN_AT      = 860;

    typedef struct packed {
        logic [63:0] column_bytes;
        logic [2:0]  page_index;
        logic [3:0]  column_group;
        logic        frame_end;
    } t_page_slice;

    class page_scoreboard;
        logic [7:0]  rows_held [rpct_pkg::STORE_ROWS][BYTES_PER_ROW];
        int unsigned row_pos;
        int unsigned byte_pos;
        int unsigned errors;
        t_page_slice pending [$];

        function new();
            row_pos  = 0;
            byte_pos = 0;
            errors   = 0;
            foreach (rows_held[r, b]) rows_held[r][b] = 8'h00;
        endfunction

        function logic [63:0] gather_columns(logic [7:0][7:0] page_rows);
            logic [63:0] cols;
            cols = '0;
            for (int k = 0; k < 8; k++) begin
                for (int c = 0; c < 8; c++) begin
                    cols[c*8+k] = page_rows[k][c];
                end
            end
            return cols;
        endfunction

        function void note_pixel(logic [7:0] px);
            int unsigned     sub_row;
            int unsigned     page;
            logic [7:0][7:0] page_rows;
            t_page_slice     slice;
            sub_row = row_pos % rpct_pkg::PAGE_ROWS;
            page    = row_pos / rpct_pkg::PAGE_ROWS;
            if (page < FULL_PAGES && byte_pos < BYTES_PER_ROW) begin
                if (sub_row < rpct_pkg::STORE_ROWS) begin
                    rows_held[sub_row][byte_pos] = px;
                end else begin
                    for (int k = 0; k < rpct_pkg::STORE_ROWS; k++) begin
                        page_rows[k] = rows_held[k][byte_pos];
                    end
                    page_rows[7]       = px;
                    slice.column_bytes = gather_columns(page_rows);
                    slice.page_index   = page[2:0];
                    slice.column_group = byte_pos[3:0];
                    slice.frame_end    = (page == FULL_PAGES - 1) &&
                                         (byte_pos == BYTES_PER_ROW - 1);
                    pending.push_back(slice);
                end
            end
            // advance position, wrap at end of frame
            byte_pos++;
            if (byte_pos >= BYTES_PER_ROW) begin
                byte_pos = 0;
                row_pos++;
                if (row_pos >= HEIGHT) row_pos = 0;
            end
        endfunction

        function void check_slice(t_page_slice got);
            t_page_slice want;
            if (pending.size() == 0) begin
                $error("column request with nothing expected: %h", got.column_bytes);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.column_bytes !== want.column_bytes) begin
                $error("column_bytes: expected %h, got %h", want.column_bytes, got.column_bytes);
                errors++;
            end
            if (got.page_index !== want.page_index) begin
                $error("page_index: expected %0d, got %0d", want.page_index, got.page_index);
                errors++;
            end
            if (got.column_group !== want.column_group) begin
                $error("column_group: expected %0d, got %0d",
                       want.column_group, got.column_group);
                errors++;
            end
            if (got.frame_end !== want.frame_end) begin
                $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [7:0]  i_pixel_byte = 8'h00;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [63:0] o_column_bytes;
    logic [2:0]  o_page_index;
    logic [3:0]  o_column_group;
    logic        o_frame_end;

    page_scoreboard sb = new();
    int unsigned    sent_count = 0;

    raster_to_page_column_transposer #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_byte   (i_pixel_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_column_bytes (o_column_bytes),
        .o_page_index   (o_page_index),
        .o_column_group (o_column_group),
        .o_frame_end    (o_frame_end)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("raster_to_page_column_transposer regression: fail");
        $finish;
    end

    function automatic bit quiet_stretch();
        return sent_count >= QUIET_FIRST && sent_count < QUIET_LAST;
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= !quiet_stretch() && ($urandom_range(99) < 6);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            sb.note_pixel(i_pixel_byte);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_slice({o_column_bytes, o_page_index, o_column_group, o_frame_end});
        end
    end

    task automatic send_pixel(input logic [7:0] px);
        @(negedge i_clk);
        while (!quiet_stretch() && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_pixel_byte <= px;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01 << $urandom_range(7);
            3:       return ~(8'h01 << $urandom_range(7));
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        logic [7:0] directed [$];
        directed = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0,
                     8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'hFE, 8'hFD,
                     8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'h33, 8'hCC};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_pixel(directed[i]);
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            if (n == DRAIN_AT) wait_drained();
            send_pixel(pick_pixel());
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("raster_to_page_column_transposer regression: pass");
        end else begin
            $display("raster_to_page_column_transposer regression: fail");
        end
        $finish;
    end

endmodule
